// ----- rtl/core/bresenham_line_rasterizer_assert.svh -----
// Assertion macros used by the rasterizer output buffer.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef BRESENHAM_LINE_RASTERIZER_ASSERT_SVH
`define BRESENHAM_LINE_RASTERIZER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BLR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BLR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/blr_pkg.sv -----
package blr_pkg;

  localparam int unsigned CoordBits = 12;
  localparam int unsigned ColorBits = 16;
  localparam int unsigned ErrBits   = CoordBits + 1;

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic [CoordBits-1:0]        span_t;
  typedef logic signed [ErrBits-1:0]   err_t;
  typedef logic [ColorBits-1:0]        color_t;

  typedef enum logic [1:0] {
    OpLine   = 2'd0,
    OpLineTo = 2'd1,
    OpMoveTo = 2'd2,
    OpStep   = 2'd3
  } blr_op_e;

  typedef struct packed {
    logic [1:0] opcode;
    coord_t     start_x;
    coord_t     start_y;
    coord_t     end_x;
    coord_t     end_y;
    color_t     pixel_color;
  } blr_in_t;

  typedef struct packed {
    coord_t out_x;
    coord_t out_y;
    color_t out_color;
    logic   on_screen;
    logic   last_pixel;
  } blr_out_t;

  // Absolute difference of two coordinates; always fits in CoordBits unsigned bits.
  function automatic span_t abs_diff(coord_t a, coord_t b);
    logic signed [CoordBits:0] diff;
    diff = {a[CoordBits-1], a} - {b[CoordBits-1], b};
    if (diff < 0) begin
      diff = -diff;
    end
    return diff[CoordBits-1:0];
  endfunction

endpackage

// ----- rtl/core/blr_in_reg.sv -----
module blr_in_reg (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  blr_pkg::blr_in_t in_data_i,
  output logic            cmd_valid_o,
  input  logic            cmd_take_i,
  output blr_pkg::blr_in_t cmd_o
);

  logic             valid_q, valid_d;
  blr_pkg::blr_in_t data_q;
  logic             load;

  assign in_ready_o = !valid_q || cmd_take_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (cmd_take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= in_data_i;
    end
  end

  assign cmd_valid_o = valid_q;
  assign cmd_o       = data_q;

endmodule

// ----- rtl/core/blr_walker.sv -----
module blr_walker #(
  parameter int unsigned SCREEN_WIDTH  = 128,
  parameter int unsigned SCREEN_HEIGHT = 160
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              exec_i,
  input  blr_pkg::blr_in_t  cmd_i,
  output logic              push_o,
  output blr_pkg::blr_out_t pix_o
);

  localparam int unsigned Cb = blr_pkg::CoordBits;
  localparam blr_pkg::coord_t ScrW = blr_pkg::coord_t'(SCREEN_WIDTH);
  localparam blr_pkg::coord_t ScrH = blr_pkg::coord_t'(SCREEN_HEIGHT);

  blr_pkg::coord_t cursor_x_q, cursor_x_d, cursor_y_q, cursor_y_d;
  blr_pkg::coord_t major_pos_q, major_pos_d, major_end_q, major_end_d;
  blr_pkg::coord_t minor_pos_q, minor_pos_d;
  blr_pkg::err_t   error_term_q, error_term_d;
  blr_pkg::span_t  major_span_q, major_span_d, minor_span_q, minor_span_d;
  logic            minor_dir_down_q, minor_dir_down_d;
  logic            axes_swapped_q, axes_swapped_d;
  logic            line_active_q, line_active_d;
  blr_pkg::color_t line_color_q, line_color_d;

  blr_pkg::blr_op_e op;
  blr_pkg::coord_t  x0, y0, x1, y1, a0, a1, b0, b1, m0, m1, n0, n1;
  blr_pkg::span_t   adx, ady, ld_major_span;
  logic             ld_swap, ld_rev;
  blr_pkg::coord_t  px, py;
  logic             last, vis;
  blr_pkg::err_t    err_sub;

  assign op = blr_pkg::blr_op_e'(cmd_i.opcode);

  // Line setup: pick the start point, swap axes for steep lines, then order the
  // end points so that the major coordinate rises.
  always_comb begin
    x0 = (op == blr_pkg::OpLine) ? cmd_i.start_x : cursor_x_q;
    y0 = (op == blr_pkg::OpLine) ? cmd_i.start_y : cursor_y_q;
    x1 = cmd_i.end_x;
    y1 = cmd_i.end_y;
    adx = blr_pkg::abs_diff(x1, x0);
    ady = blr_pkg::abs_diff(y1, y0);
    ld_swap = ady > adx;
    a0 = ld_swap ? y0 : x0;
    b0 = ld_swap ? x0 : y0;
    a1 = ld_swap ? y1 : x1;
    b1 = ld_swap ? x1 : y1;
    ld_rev = a0 > a1;
    m0 = ld_rev ? a1 : a0;
    m1 = ld_rev ? a0 : a1;
    n0 = ld_rev ? b1 : b0;
    n1 = ld_rev ? b0 : b1;
    ld_major_span = blr_pkg::span_t'(m1 - m0);
  end

  // Current pixel of the walker.
  always_comb begin
    px   = axes_swapped_q ? minor_pos_q : major_pos_q;
    py   = axes_swapped_q ? major_pos_q : minor_pos_q;
    last = major_pos_q >= major_end_q;
    vis  = !px[Cb-1] && (px < ScrW) && !py[Cb-1] && (py < ScrH);
    err_sub = error_term_q - blr_pkg::err_t'({1'b0, minor_span_q});
  end

  always_comb begin
    cursor_x_d       = cursor_x_q;
    cursor_y_d       = cursor_y_q;
    major_pos_d      = major_pos_q;
    major_end_d      = major_end_q;
    minor_pos_d      = minor_pos_q;
    error_term_d     = error_term_q;
    major_span_d     = major_span_q;
    minor_span_d     = minor_span_q;
    minor_dir_down_d = minor_dir_down_q;
    axes_swapped_d   = axes_swapped_q;
    line_active_d    = line_active_q;
    line_color_d     = line_color_q;
    push_o           = 1'b0;
    if (exec_i) begin
      case (op)
        blr_pkg::OpLine, blr_pkg::OpLineTo: begin
          cursor_x_d       = x1;
          cursor_y_d       = y1;
          axes_swapped_d   = ld_swap;
          major_pos_d      = m0;
          major_end_d      = m1;
          minor_pos_d      = n0;
          major_span_d     = ld_major_span;
          minor_span_d     = blr_pkg::abs_diff(n1, n0);
          error_term_d     = blr_pkg::err_t'({1'b0, ld_major_span} >> 1);
          minor_dir_down_d = !(n0 < n1);
          line_color_d     = cmd_i.pixel_color;
          line_active_d    = 1'b1;
        end
        blr_pkg::OpMoveTo: begin
          cursor_x_d = cmd_i.end_x;
          cursor_y_d = cmd_i.end_y;
        end
        blr_pkg::OpStep: begin
          if (line_active_q) begin
            push_o = 1'b1;
            if (last) begin
              line_active_d = 1'b0;
            end else begin
              // The error never drops below minus the major span, so one
              // correction brings it back to zero or above.
              if (err_sub < 0) begin
                minor_pos_d  = minor_dir_down_q ? minor_pos_q - 1'b1 : minor_pos_q + 1'b1;
                error_term_d = err_sub + blr_pkg::err_t'({1'b0, major_span_q});
              end else begin
                error_term_d = err_sub;
              end
              major_pos_d = major_pos_q + 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_x_q       <= '0;
      cursor_y_q       <= '0;
      major_pos_q      <= '0;
      major_end_q      <= '0;
      minor_pos_q      <= '0;
      error_term_q     <= '0;
      major_span_q     <= '0;
      minor_span_q     <= '0;
      minor_dir_down_q <= 1'b0;
      axes_swapped_q   <= 1'b0;
      line_active_q    <= 1'b0;
      line_color_q     <= '0;
    end else begin
      cursor_x_q       <= cursor_x_d;
      cursor_y_q       <= cursor_y_d;
      major_pos_q      <= major_pos_d;
      major_end_q      <= major_end_d;
      minor_pos_q      <= minor_pos_d;
      error_term_q     <= error_term_d;
      major_span_q     <= major_span_d;
      minor_span_q     <= minor_span_d;
      minor_dir_down_q <= minor_dir_down_d;
      axes_swapped_q   <= axes_swapped_d;
      line_active_q    <= line_active_d;
      line_color_q     <= line_color_d;
    end
  end

  assign pix_o.out_x      = px;
  assign pix_o.out_y      = py;
  assign pix_o.out_color  = line_color_q;
  assign pix_o.on_screen  = vis;
  assign pix_o.last_pixel = last;

endmodule

// ----- rtl/core/blr_out_buf.sv -----
`include "bresenham_line_rasterizer_assert.svh"

module blr_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  blr_pkg::blr_out_t push_data_i,
  output logic              space_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output blr_pkg::blr_out_t out_data_o
);

  logic              out_valid_q, out_valid_d;
  logic              skid_valid_q, skid_valid_d;
  blr_pkg::blr_out_t out_data_q, skid_data_q;
  logic              out_fire;

  // Space is taken from a register so that the upstream side never waits on
  // the downstream ready within the same cycle.
  assign space_o  = !skid_valid_q;
  assign out_fire = out_valid_q && out_ready_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (!out_valid_q || out_fire) begin
      out_valid_d  = skid_valid_q || push_i;
      skid_valid_d = 1'b0;
    end else if (push_i) begin
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_fire) begin
      out_data_q <= skid_valid_q ? skid_data_q : push_data_i;
    end else if (push_i) begin
      skid_data_q <= push_data_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `BLR_ASSERT_SAME(a_skid_behind_out, skid_valid_q, out_valid_q, "skid holds data while output is empty")
  `BLR_ASSERT_SAME(a_no_push_when_full, push_i, !skid_valid_q, "pixel pushed into a full buffer")
  `BLR_ASSERT_NEXT(a_drain_empties, out_fire && !skid_valid_q && !push_i, !out_valid_q, "output stayed valid after its last transfer")

endmodule

// ----- rtl/core/bresenham_line_rasterizer.sv -----
// Bresenham line rasterizer with a pen cursor.
// Input channel (in_valid_i / in_ready_o / in_data_i) carries commands: line,
// line_to from the cursor, move_to, and step. Only a step taken while a line is
// active produces a transfer on the output channel (out_valid_o / out_ready_i /
// out_data_o), which carries the pixel, its color, an on-screen flag and a
// last-pixel flag. Line commands set up the walker and abort any line in
// progress; the first pixel comes with the next step.
// A step's pixel passes through the input register, is computed by the walker
// and is loaded into the result register.
// Throughput: one command per cycle while the output buffer has room. The walker
// does one add, compare and conditional add per step, so a pixel per cycle holds.
// A two-entry output buffer (result register plus skid register) absorbs a
// stall: commands keep flowing until both entries and the input register are
// full, then in_ready_o drops until the receiver takes a pixel. Commands that give
// no pixel still wait behind a full buffer to keep ordering simple.
// Reset clears the cursor and walker state to zero with no line active and
// empties both the input register and the output buffer.
module bresenham_line_rasterizer #(
  parameter int unsigned SCREEN_WIDTH  = 128,
  parameter int unsigned SCREEN_HEIGHT = 160
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  blr_pkg::blr_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output blr_pkg::blr_out_t out_data_o
);

  logic              cmd_valid, cmd_take, space, push;
  blr_pkg::blr_in_t  cmd;
  blr_pkg::blr_out_t pix;

  // A buffered command executes once the output buffer has room for a pixel.
  assign cmd_take = cmd_valid && space;

  blr_in_reg u_in_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cmd_valid_o (cmd_valid),
    .cmd_take_i  (cmd_take),
    .cmd_o       (cmd)
  );

  blr_walker #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_walker (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .exec_i (cmd_take),
    .cmd_i  (cmd),
    .push_o (push),
    .pix_o  (pix)
  );

  blr_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (pix),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- tb/sv/tb_bresenham_line_rasterizer.sv -----
`timescale 1ns / 1ps

module tb_bresenham_line_rasterizer;

  localparam int ScreenW     = 128;
  localparam int ScreenH     = 160;
  localparam int RandomItems = 1800;
  localparam int HoldAtPixel = 300;
  localparam int HoldCycles  = 250;

  logic              clk_i     = 1'b0;
  logic              rst_ni    = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  blr_pkg::blr_in_t  in_data   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  blr_pkg::blr_out_t out_data;

  bresenham_line_rasterizer #(
    .SCREEN_WIDTH (ScreenW),
    .SCREEN_HEIGHT(ScreenH)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  always #5 clk_i = ~clk_i;

  blr_pkg::blr_in_t  cmd_q[$];
  blr_pkg::blr_out_t pixel_q[$];

  // Walker and pen state of the line model, cleared as after reset.
  blr_pkg::coord_t pen_x = '0, pen_y = '0;
  blr_pkg::coord_t maj_pos = '0, maj_end = '0, min_pos = '0;
  blr_pkg::err_t   err_acc = '0;
  blr_pkg::span_t  maj_span = '0, min_span = '0;
  logic            min_down = 1'b0, swapped = 1'b0, drawing = 1'b0;
  blr_pkg::color_t line_col = '0;

  int errors         = 0;
  int pixels_checked = 0;
  int cmds_sent      = 0;
  int lines_loaded   = 0;
  int gen_live       = 0;
  int gen_x          = 0;
  int gen_y          = 0;
  int send_gap       = 0;
  int send_calm      = 0;
  int recv_stall     = 0;
  int recv_calm      = 0;

  function automatic int iabs(int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic int clamp_coord(int v);
    if (v < -2048) return -2048;
    if (v > 2047) return 2047;
    return v;
  endfunction

  function automatic int rnd_int_coord();
    return int'($urandom_range(0, 4095)) - 2048;
  endfunction

  function automatic void load_walker(blr_pkg::coord_t x0, blr_pkg::coord_t y0,
                                      blr_pkg::coord_t x1, blr_pkg::coord_t y1,
                                      blr_pkg::color_t col);
    int ax0, ay0, ax1, ay1, t;
    ax0 = x0;
    ay0 = y0;
    ax1 = x1;
    ay1 = y1;
    pen_x = x1;
    pen_y = y1;
    swapped = iabs(ay1 - ay0) > iabs(ax1 - ax0);
    if (swapped) begin
      t = ax0; ax0 = ay0; ay0 = t;
      t = ax1; ax1 = ay1; ay1 = t;
    end
    if (ax0 > ax1) begin
      t = ax0; ax0 = ax1; ax1 = t;
      t = ay0; ay0 = ay1; ay1 = t;
    end
    maj_pos  = blr_pkg::coord_t'(ax0);
    maj_end  = blr_pkg::coord_t'(ax1);
    min_pos  = blr_pkg::coord_t'(ay0);
    maj_span = blr_pkg::span_t'(ax1 - ax0);
    min_span = blr_pkg::span_t'(iabs(ay1 - ay0));
    err_acc  = blr_pkg::err_t'((ax1 - ax0) >>> 1);
    min_down = !(ay0 < ay1);
    line_col = col;
    drawing  = 1'b1;
  endfunction

  function automatic void step_walker();
    blr_pkg::blr_out_t pix;
    int px, py, e;
    if (!drawing) return;
    px = swapped ? int'(min_pos) : int'(maj_pos);
    py = swapped ? int'(maj_pos) : int'(min_pos);
    pix.out_x      = blr_pkg::coord_t'(px);
    pix.out_y      = blr_pkg::coord_t'(py);
    pix.out_color  = line_col;
    pix.on_screen  = (px >= 0) && (px < ScreenW) && (py >= 0) && (py < ScreenH);
    pix.last_pixel = (maj_pos >= maj_end);
    pixel_q.push_back(pix);
    if (pix.last_pixel) begin
      drawing = 1'b0;
    end else begin
      e = int'(err_acc) - int'(min_span);
      if (e < 0) begin
        min_pos = min_pos + (min_down ? -1 : 1);
        e = e + int'(maj_span);
      end
      err_acc = blr_pkg::err_t'(e);
      maj_pos = maj_pos + 1;
    end
  endfunction

  function automatic void predict_pixels(blr_pkg::blr_in_t it);
    case (blr_pkg::blr_op_e'(it.opcode))
      blr_pkg::OpLine:
        load_walker(it.start_x, it.start_y, it.end_x, it.end_y, it.pixel_color);
      blr_pkg::OpLineTo:
        load_walker(pen_x, pen_y, it.end_x, it.end_y, it.pixel_color);
      blr_pkg::OpMoveTo: begin
        pen_x = it.end_x;
        pen_y = it.end_y;
      end
      default:  step_walker();
    endcase
  endfunction

  // Fields that the opcode does not use get random content.
  function automatic void push_item(blr_pkg::blr_op_e op, int sx, int sy, int ex, int ey,
                                    int col, bit live);
    blr_pkg::blr_in_t it;
    it.opcode      = op;
    it.start_x     = (op == blr_pkg::OpLine) ? blr_pkg::coord_t'(sx)
                                             : blr_pkg::coord_t'($urandom);
    it.start_y     = (op == blr_pkg::OpLine) ? blr_pkg::coord_t'(sy)
                                             : blr_pkg::coord_t'($urandom);
    it.end_x       = (op == blr_pkg::OpStep) ? blr_pkg::coord_t'($urandom)
                                             : blr_pkg::coord_t'(ex);
    it.end_y       = (op == blr_pkg::OpStep) ? blr_pkg::coord_t'($urandom)
                                             : blr_pkg::coord_t'(ey);
    it.pixel_color = (op == blr_pkg::OpLine || op == blr_pkg::OpLineTo)
                     ? blr_pkg::color_t'(col) : blr_pkg::color_t'($urandom);
    cmd_q.push_back(it);
    if (op != blr_pkg::OpStep) begin
      gen_x = ex;
      gen_y = ey;
    end
    if (live) gen_live++;
  endfunction

  function automatic void push_steps(int n, bit live);
    repeat (n) push_item(blr_pkg::OpStep, 0, 0, 0, 0, 0, live);
  endfunction

  function automatic void add_segment();
    int kind, sx, sy, ex, ey, span, need, nsteps, sel, mid;
    blr_pkg::blr_op_e op;
    kind = $urandom_range(0, 19);
    if (kind == 0) begin
      op = blr_pkg::blr_op_e'($urandom_range(0, 3));
      push_item(op, rnd_int_coord(), rnd_int_coord(), rnd_int_coord(), rnd_int_coord(),
                $urandom, 1);
      return;
    end
    if (kind == 1) begin
      // A line anywhere in the coordinate range, cut short by whatever follows.
      push_item(blr_pkg::OpLine, rnd_int_coord(), rnd_int_coord(), rnd_int_coord(),
                rnd_int_coord(), $urandom, 1);
      push_steps($urandom_range(0, 6), 1);
      return;
    end
    if (kind == 2) begin
      if ($urandom_range(0, 1))
        push_item(blr_pkg::OpMoveTo, 0, 0, rnd_int_coord(), rnd_int_coord(), 0, 1);
      else
        push_item(blr_pkg::OpMoveTo, 0, 0, int'($urandom_range(0, 200)) - 30,
                  int'($urandom_range(0, 230)) - 30, 0, 1);
      return;
    end
    span = (kind < 6) ? 60 : 12;
    if (kind < 10) begin
      op = blr_pkg::OpLineTo;
      sx = gen_x;
      sy = gen_y;
    end else begin
      op = blr_pkg::OpLine;
      sx = int'($urandom_range(0, 200)) - 30;
      sy = int'($urandom_range(0, 230)) - 30;
    end
    ex = clamp_coord(sx + int'($urandom_range(0, 2 * span)) - span);
    ey = clamp_coord(sy + int'($urandom_range(0, 2 * span)) - span);
    need = ((iabs(ex - sx) > iabs(ey - sy)) ? iabs(ex - sx) : iabs(ey - sy)) + 1;
    sel = $urandom_range(0, 9);
    nsteps = (sel < 8) ? need : int'($urandom_range(0, need - 1));
    mid = ($urandom_range(0, 7) == 0) ? nsteps / 2 : -1;
    push_item(op, sx, sy, ex, ey, $urandom, 1);
    for (int i = 0; i < nsteps; i++) begin
      if (i == mid)
        push_item(blr_pkg::OpMoveTo, 0, 0, int'($urandom_range(0, 200)) - 30,
                  int'($urandom_range(0, 230)) - 30, 0, 1);
      push_item(blr_pkg::OpStep, 0, 0, 0, 0, 0, 1);
    end
    if (sel == 7) push_steps($urandom_range(1, 2), 0);
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // Command driver: one transfer per accepted item, random gaps between items.
  always @(posedge clk_i or negedge rst_ni) begin : cmd_driver
    int gap_n;
    if (!rst_ni) begin
      in_valid  <= 1'b0;
      in_data   <= '0;
      send_gap  <= 0;
      send_calm <= 0;
    end else begin
      if (in_valid && in_ready) begin
        predict_pixels(in_data);
        cmds_sent++;
        if (in_data.opcode == blr_pkg::OpLine || in_data.opcode == blr_pkg::OpLineTo)
          lines_loaded++;
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          in_valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (cmd_q.size() > 0) begin
          in_data  <= cmd_q.pop_front();
          in_valid <= 1'b1;
          if (send_calm > 0) begin
            gap_n = 0;
            send_calm <= send_calm - 1;
          end else begin
            gap_n = $urandom_range(0, 1) ? 0 : $urandom_range(0, 14);
            if ($urandom_range(0, 31) == 0) send_calm <= $urandom_range(20, 60);
          end
          send_gap <= gap_n;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Pixel monitor: checks each output transfer and stalls the receiver at random.
  always @(posedge clk_i or negedge rst_ni) begin : pixel_monitor
    blr_pkg::blr_out_t want;
    int wait_n;
    if (!rst_ni) begin
      out_ready  <= 1'b0;
      recv_stall <= 0;
      recv_calm  <= 0;
    end else begin
      wait_n = (recv_stall > 0) ? recv_stall - 1 : 0;
      if (out_valid && out_ready) begin
        pixels_checked++;
        if (pixel_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected pixel, expected none, got %p", $time, out_data);
        end else begin
          want = pixel_q.pop_front();
          check_field("out_x", int'(want.out_x), int'(out_data.out_x));
          check_field("out_y", int'(want.out_y), int'(out_data.out_y));
          check_field("out_color", int'(want.out_color), int'(out_data.out_color));
          check_field("on_screen", int'(want.on_screen), int'(out_data.on_screen));
          check_field("last_pixel", int'(want.last_pixel), int'(out_data.last_pixel));
        end
        if (recv_calm > 0) begin
          wait_n = 0;
          recv_calm <= recv_calm - 1;
        end else begin
          wait_n = $urandom_range(0, 1) ? 0 : $urandom_range(0, 14);
          if ($urandom_range(0, 31) == 0) recv_calm <= $urandom_range(20, 60);
        end
        // One long hold-off lets the commands back up until the input stalls.
        if (pixels_checked == HoldAtPixel) wait_n = HoldCycles;
      end
      recv_stall <= wait_n;
      out_ready  <= (wait_n == 0);
    end
  end

  initial begin
    int target;
    // Step with no line loaded, then a single-point line.
    push_item(blr_pkg::OpStep, 0, 0, 0, 0, 0, 1);
    push_item(blr_pkg::OpLine, 0, 0, 0, 0, 16'hFFFF, 1);
    push_steps(1, 1);
    push_item(blr_pkg::OpStep, 0, 0, 0, 0, 0, 1);
    // Full-range diagonal, aborted after two pixels by a steep line with falling x.
    push_item(blr_pkg::OpLine, -2048, -2048, 2047, 2047, 16'h0000, 1);
    push_steps(2, 1);
    push_item(blr_pkg::OpLine, 2047, -2048, 2040, 2047, 16'hA5A5, 1);
    push_steps(2, 1);
    // Moving the pen does not disturb the line being drawn.
    push_item(blr_pkg::OpMoveTo, 0, 0, 5, 7, 0, 1);
    push_steps(1, 1);
    push_item(blr_pkg::OpLineTo, 0, 0, 8, 3, 16'h07E0, 1);
    push_steps(5, 1);
    // Screen edges: each line has pixels outside the screen.
    push_item(blr_pkg::OpLine, 127, 159, 128, 160, 16'hF800, 1);
    push_steps(2, 1);
    push_item(blr_pkg::OpLine, -1, 0, 0, -1, 16'h001F, 1);
    push_steps(2, 1);
    push_item(blr_pkg::OpLineTo, 0, 0, 2047, -2048, 16'h5555, 1);
    push_steps(1, 1);
    target = gen_live + RandomItems;
    while (gen_live < target) add_segment();

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (cmd_q.size() != 0 || in_valid) @(posedge clk_i);
    while (pixel_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    $display("Run covered %0d commands (%0d line loads) and %0d checked pixels,",
             cmds_sent, lines_loaded, pixels_checked);
    $display("with random gaps on both sides and one long output hold-off.");
    if (errors == 0) begin
      $display("[bresenham_line_rasterizer] OK");
    end else begin
      $display("[bresenham_line_rasterizer] ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout with %0d commands queued and %0d pixels outstanding.",
             cmd_q.size(), pixel_q.size());
    $display("[bresenham_line_rasterizer] ERROR");
    $finish;
  end

endmodule
